FILE: rtl/core/ifsf_pkg.sv
// ----------------------------------------------------------------------------
// ifsf_pkg - shared types and constants of the information frame framer
// Operation codes, framing byte values and the byte buffer depth.
// ----------------------------------------------------------------------------
package ifsf_pkg;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DATA  = 2'd1,
      OP_END   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [7:0] FRAME_FLAG   = 8'h7E;
   localparam logic [7:0] ESCAPE_BYTE  = 8'h7D;
   localparam logic [7:0] FLAG_SUBST   = 8'h5E;
   localparam logic [7:0] ESCAPE_SUBST = 8'h5D;
   localparam logic [7:0] ADDRESS_RST  = 8'h03;

   // most bytes one input word can produce
   localparam int unsigned MAX_BYTES = 4;
   localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

endpackage

FILE: rtl/core/info_frame_stuffing_framer_top.sv
// ----------------------------------------------------------------------------
// info_frame_stuffing_framer_top - byte-stuffing framer with XOR block check
// Turns start, payload and end words into the bytes of a stuffed frame.
// ----------------------------------------------------------------------------
// Each accepted word is expanded at once into a small byte buffer (4 bytes
// for a start, 1 or 2 for a payload byte, 2 or 3 for an end, none for the
// unused op code), and the buffer drains one byte per cycle into the output
// register while rsp_tready does not stall it, so output is one byte per
// cycle too. A word with the unused op code produces no bytes. The first
// byte of a word goes from the byte buffer to the output register once the
// word is taken. The next word is taken in the cycle the buffer hands on
// its last byte, so there is no gap between words. rsp_tlast marks the last
// byte of each word.
// The address register may only be written while no frame bytes are pending.
module info_frame_stuffing_framer_top
   import ifsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata,   // address_byte
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] control_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   // output bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast    // run_last
);

   logic [7:0]       address_ff;
   logic [7:0]       check_ff, check_in;
   logic [7:0]       pend_ff [MAX_BYTES];
   logic [7:0]       pend_in [MAX_BYTES];
   logic [CNT_W-1:0] left_ff, left_in;
   logic [7:0]       new_byte [MAX_BYTES];
   logic [CNT_W-1:0] new_cnt;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_data_ff;
   logic             rsp_last_ff;
   logic             move;
   logic             accept;
   op_type           op;
   logic [7:0]       data_byte;
   logic [7:0]       control_byte;
   logic [7:0]       end_check;

   assign op           = op_type'(req_tuser);
   assign data_byte    = req_tdata[7:0];
   assign control_byte = req_tdata[15:8];

   assign move   = (left_ff != '0) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (left_ff == '0) ||
                       ((left_ff == CNT_W'(1)) && move);
   assign accept = req_tvalid && req_tready;

   assign end_check = check_ff;

   // expand one word into its bytes
   always_comb begin
      for (int i = 0; i < MAX_BYTES; i++) begin
         new_byte[i] = FRAME_FLAG;
      end
      new_cnt  = '0;
      check_in = check_ff;
      unique case (op)
         OP_START: begin
            new_byte[0] = FRAME_FLAG;
            new_byte[1] = address_ff;
            new_byte[2] = control_byte;
            new_byte[3] = address_ff ^ control_byte;
            new_cnt     = CNT_W'(4);
            check_in    = '0;
         end
         OP_DATA: begin
            check_in = check_ff ^ data_byte;
            if (data_byte == FRAME_FLAG) begin
               new_byte[0] = ESCAPE_BYTE;
               new_byte[1] = FLAG_SUBST;
               new_cnt     = CNT_W'(2);
            end else if (data_byte == ESCAPE_BYTE) begin
               new_byte[0] = ESCAPE_BYTE;
               new_byte[1] = ESCAPE_SUBST;
               new_cnt     = CNT_W'(2);
            end else begin
               new_byte[0] = data_byte;
               new_cnt     = CNT_W'(1);
            end
         end
         OP_END: begin
            if (end_check == FRAME_FLAG) begin
               new_byte[0] = ESCAPE_BYTE;
               new_byte[1] = FLAG_SUBST;
               new_byte[2] = FRAME_FLAG;
               new_cnt     = CNT_W'(3);
            end else if (end_check == ESCAPE_BYTE) begin
               new_byte[0] = ESCAPE_BYTE;
               new_byte[1] = ESCAPE_SUBST;
               new_byte[2] = FRAME_FLAG;
               new_cnt     = CNT_W'(3);
            end else begin
               new_byte[0] = end_check;
               new_byte[1] = FRAME_FLAG;
               new_cnt     = CNT_W'(2);
            end
         end
         OP_NONE: begin
            new_cnt = '0;
         end
         default: begin
            new_cnt = '0;
         end
      endcase
   end

   // load a fresh word, or advance the buffer by one byte
   always_comb begin
      for (int i = 0; i < MAX_BYTES; i++) begin
         pend_in[i] = pend_ff[i];
      end
      left_in = left_ff;
      if (accept) begin
         for (int i = 0; i < MAX_BYTES; i++) begin
            pend_in[i] = new_byte[i];
         end
         left_in = new_cnt;
      end else if (move) begin
         for (int i = 0; i < MAX_BYTES - 1; i++) begin
            pend_in[i] = pend_ff[i+1];
         end
         left_in = left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff   <= ADDRESS_RST;
         check_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            address_ff <= csr_wdata;
         end
         if (accept) begin
            check_ff <= check_in;
         end
         left_ff <= left_in;
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_BYTES; i++) begin
         pend_ff[i] <= pend_in[i];
      end
      if (move) begin
         rsp_data_ff <= pend_ff[0];
         rsp_last_ff <= (left_ff == CNT_W'(1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/core/ifsf_checker.sv
// ----------------------------------------------------------------------------
// ifsf_checker - port-level checks of the information frame framer
// Watches the output stream for stalls, reset and byte continuity.
// ----------------------------------------------------------------------------
module ifsf_checker
   import ifsf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // hold a stalled output byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast))
      else $error("output byte changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("framer not idle after reset");

   // bytes of one word follow without a bubble
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside the bytes of one word");

endmodule

bind info_frame_stuffing_framer_top ifsf_checker u_ifsf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: bench/info_frame_stuffing_framer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_frame_stuffing_framer_top_tb - self-checking bench of the frame framer
// Sends start, payload and end words and predicts every stuffed line byte,
// including headers, escapes and the XOR check. Each byte is compared as it
// leaves the block. Both stream sides stall at random, and the address is
// rewritten between phases while the line is idle.
// ----------------------------------------------------------------------------
module info_frame_stuffing_framer_top_tb;
   import ifsf_pkg::*;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } line_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_wen    = 1'b0;
   logic [7:0]  csr_wdata  = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;   // [7:0] data_byte, [15:8] control_byte
   logic [1:0]  req_tuser  = OP_NONE;    // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;               // [7:0] out_byte
   logic        rsp_tlast;

   // predictor state
   logic [7:0]    address_reg = ADDRESS_RST;
   logic [7:0]    check_xor   = 8'h00;
   line_byte_type expected_line_q[$];

   int          sender_idle_pct   = 0;
   int          receiver_idle_pct = 0;
   int          mismatch_count    = 0;
   int          words_sent        = 0;

   info_frame_stuffing_framer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   function automatic void push_line_byte(input logic [7:0] b, input logic last);
      line_byte_type lb;
      lb.value = b;
      lb.last  = last;
      expected_line_q.push_back(lb);
   endfunction

   function automatic void push_stuffed_byte(input logic [7:0] b, input logic last);
      if (b == FRAME_FLAG) begin
         push_line_byte(ESCAPE_BYTE, 1'b0);
         push_line_byte(FLAG_SUBST, last);
      end else if (b == ESCAPE_BYTE) begin
         push_line_byte(ESCAPE_BYTE, 1'b0);
         push_line_byte(ESCAPE_SUBST, last);
      end else begin
         push_line_byte(b, last);
      end
   endfunction

   function automatic void predict_frame_bytes(input op_type op, input logic [7:0] data,
                                               input logic [7:0] ctrl);
      case (op)
         OP_START: begin
            check_xor = 8'h00;
            push_line_byte(FRAME_FLAG, 1'b0);
            push_line_byte(address_reg, 1'b0);
            push_line_byte(ctrl, 1'b0);
            push_line_byte(address_reg ^ ctrl, 1'b1);
         end
         OP_DATA: begin
            push_stuffed_byte(data, 1'b1);
            check_xor = check_xor ^ data;
         end
         OP_END: begin
            push_stuffed_byte(check_xor, 1'b0);
            push_line_byte(FRAME_FLAG, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // line side: check each accepted byte, then pick next cycle's ready
   always @(posedge clock) begin
      line_byte_type exp_byte;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_line_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_tdata));
         end else begin
            exp_byte = expected_line_q.pop_front();
            if (rsp_tdata !== exp_byte.value)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_tdata, exp_byte.value));
            if (rsp_tlast !== exp_byte.last)
               report_mismatch($sformatf("run_last %0b, want %0b on byte %02h",
                                         rsp_tlast, exp_byte.last, exp_byte.value));
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   task automatic send_word(input op_type op, input logic [7:0] data, input logic [7:0] ctrl);
      // idle the sender cycle by cycle
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {ctrl, data};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_frame_bytes(op, data, ctrl);
      if (op != OP_NONE) words_sent++;
   endtask

   // drop valid, wait for the line to drain, then let the block settle
   task automatic wait_line_idle(input int settle);
      req_tvalid <= 1'b0;
      while (expected_line_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] addr);
      wait_line_idle(8);
      csr_wen   <= 1'b1;
      csr_wdata <= addr;
      @(posedge clock);
      address_reg = addr;
      csr_wen <= 1'b0;
   endtask

   function automatic logic [7:0] pick_payload_byte();
      case ($urandom_range(9))
         0, 1: return FRAME_FLAG;
         2, 3: return ESCAPE_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_frame();
      int n;
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      send_word(OP_START, 8'($urandom), 8'($urandom));
      repeat (n) send_word(OP_DATA, pick_payload_byte(), 8'($urandom));
      send_word(OP_END, 8'($urandom), 8'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_orphan_words();
      // payload and end before any start, using the check as it stands
      send_word(OP_DATA, 8'h55, 8'hFF);
      send_word(OP_END, 8'hFF, 8'h00);
      send_word(OP_END, 8'h00, 8'hFF);   // end leaves the check as it was
   endtask

   task automatic test_stuffing_extremes();
      send_word(OP_START, 8'hFF, 8'h00);
      send_word(OP_DATA, FRAME_FLAG, 8'h00);
      send_word(OP_DATA, ESCAPE_BYTE, 8'hFF);
      send_word(OP_DATA, 8'h00, 8'h00);
      send_word(OP_DATA, 8'hFF, 8'hFF);
      send_word(OP_DATA, 8'h7C, 8'h00);
      send_word(OP_DATA, 8'h7F, 8'h00);
      send_word(OP_END, 8'h00, 8'h00);
   endtask

   task automatic test_stuffed_check();
      // check byte equal to the flag, then equal to the escape
      send_word(OP_START, 8'h00, 8'hFF);
      send_word(OP_DATA, FRAME_FLAG, 8'h00);
      send_word(OP_END, 8'h00, 8'h00);
      send_word(OP_START, 8'h00, 8'h7E);
      send_word(OP_DATA, ESCAPE_BYTE, 8'h00);
      send_word(OP_END, 8'h00, 8'h00);
   endtask

   task automatic test_empty_and_restart();
      send_word(OP_START, 8'h00, 8'h01);
      send_word(OP_END, 8'h00, 8'h00);
      send_word(OP_START, 8'h00, 8'h02);
      send_word(OP_DATA, 8'hA5, 8'h00);
      send_word(OP_START, 8'h00, 8'h03);   // restart clears the check again
      send_word(OP_NONE, 8'hFF, 8'hFF);    // unused op, no bytes
      send_word(OP_NONE, 8'h00, 8'h00);
      send_word(OP_END, 8'h00, 8'h00);
   endtask

   task automatic test_address_extremes();
      write_address(8'h00);
      send_word(OP_START, 8'h00, FRAME_FLAG);
      send_word(OP_END, 8'h00, 8'h00);
      write_address(8'hFF);
      send_word(OP_START, 8'h00, 8'h82);   // header check lands on the escape
      send_word(OP_END, 8'h00, 8'h00);
      write_address(FRAME_FLAG);
      send_word(OP_START, 8'h00, 8'h00);
      send_word(OP_END, 8'h00, 8'h00);
   endtask

   task automatic test_random_traffic(input int s_idle, input int r_idle, input int words);
      int target;
      bit held;
      target = words_sent + words;
      held = 1'b0;
      sender_idle_pct   = s_idle;
      receiver_idle_pct = r_idle;
      write_address(8'($urandom));
      while (words_sent < target) begin
         if ($urandom_range(99) < 85) begin
            send_random_frame();
         end else begin
            send_word(op_type'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
         end
         // hold the sender once until the line has drained
         if (!held && words_sent > target - words / 2) begin
            wait_line_idle(1);
            held = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct   = 18;
      receiver_idle_pct = 77;
      test_orphan_words();
      test_stuffing_extremes();
      test_stuffed_check();
      test_empty_and_restart();
      test_address_extremes();

      test_random_traffic(18, 77, 115);
      test_random_traffic(77, 18, 115);
      test_random_traffic(0, 0, 115);

      wait_line_idle(20);
      if (mismatch_count == 0 && expected_line_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
